/* sv/mwcs_pkg.sv */
// ----------------------------------------------------------------------------
// mwcs_pkg: shared definitions for the minimum window cover search unit
// Sizes, opcodes, sequencer states and the count table control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mwcs_pkg;

   localparam int SYM_W      = 7;
   localparam int ALPHA_SIZE = 128;
   localparam int TEXT_DEPTH = 4096;
   localparam int TEXT_AW    = 12;
   localparam int POS_W      = 13;
   localparam int PCNT_W     = 8;
   localparam int WCNT_W     = 13;
   localparam int LEN_W      = 13;

   localparam logic [PCNT_W-1:0] MAX_PATTERN = 8'd255;

   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_PATTERN = 2'd1;
   localparam logic [1:0] OP_TEXT    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAT_UPD,
      ST_TXT_UPD,
      ST_LEFT_RD,
      ST_LEFT_CHR,
      ST_LEFT_CMP,
      ST_DONE
   } state_type;

   // control bundle for one count table
   typedef struct packed {
      logic             clear;
      logic             we;
      logic [SYM_W-1:0] addr;
   } tbl_ctl_type;

endpackage

`default_nettype wire

/* sv/mwcs_if.sv */
// ----------------------------------------------------------------------------
// mwcs_if: request and response channels
// Valid/ready channels carrying the query opcode and the search result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwcs_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic [mwcs_pkg::SYM_W-1:0] symbol;

   modport source (output valid, output opcode, output symbol, input ready);
   modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

interface mwcs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [mwcs_pkg::TEXT_AW-1:0]  window_start;
   logic [mwcs_pkg::LEN_W-1:0]    window_length;
   logic                          overflow;

   modport source (output valid, output found, output window_start,
                   output window_length, output overflow, input ready);
   modport sink   (input valid, input found, input window_start,
                   input window_length, input overflow, output ready);
endinterface

`default_nettype wire

/* sv/mwcs_count_table.sv */
// ----------------------------------------------------------------------------
// mwcs_count_table: per-symbol counter memory
// Single-address table with registered read and a valid bit per entry so
// that a clear takes effect without walking the entries.
// ----------------------------------------------------------------------------
`default_nettype none

module mwcs_count_table #(
   parameter int DATA_W = mwcs_pkg::PCNT_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mwcs_pkg::tbl_ctl_type ctl,
   input  wire logic [DATA_W-1:0]     wr_data,
   output logic      [DATA_W-1:0]     rd_data
);

   logic [DATA_W-1:0]               mem [mwcs_pkg::ALPHA_SIZE];
   logic [mwcs_pkg::ALPHA_SIZE-1:0] valid_ff;
   logic [DATA_W-1:0]               rd_data_ff;
   logic                            rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.addr] <= wr_data;
      end
      rd_data_ff <= mem[ctl.addr];
   end

   // entry not written since clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.we) begin
         valid_ff[ctl.addr] <= 1'b1;
      end
      rd_valid_ff <= valid_ff[ctl.addr];
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* sv/minimum_window_cover_search_unit.sv */
// ----------------------------------------------------------------------------
// minimum_window_cover_search_unit: shortest covering window search
// Streams pattern and text symbols and reports the shortest text window
// holding every pattern symbol, repeats counted, after each transaction.
// ----------------------------------------------------------------------------
// A query opens with a clear transaction (opcode 0), continues with pattern
// symbols (opcode 1) and then text symbols (opcode 2); every transaction
// returns one response with found, window_start, window_length and the
// sticky overflow flag. Pattern symbols after the first text symbol are
// ignored; the 256th pattern symbol and the 4097th text symbol are dropped
// and raise overflow. Opcode 3 only reports the current result. One
// transaction is in work at a time and req.ready is low meanwhile. A clear,
// opcode 3 or a dropped symbol goes straight to the response state, a pattern
// or text symbol through a table update state first; a text symbol that
// completes a cover then trims each surplus symbol off the left edge in a
// read, fetch and compare pass and scores the window. One small sequencer
// walks the count tables, each single-port, and the text store, all with
// registered reads. Clear takes effect at once through per-entry valid
// bits; the text store needs no clearing. The response sits in an output
// register, so a new transaction is taken while a result waits as long as
// that register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_window_cover_search_unit (
   input wire logic clock,
   input wire logic reset,
   mwcs_req_if.sink   req_ch,
   mwcs_rsp_if.source rsp_ch
);

   // sequencer and query state
   mwcs_pkg::state_type               state_ff, state_in;
   logic [mwcs_pkg::POS_W-1:0]        pos_ff, pos_in;          // text symbols taken
   logic [mwcs_pkg::POS_W-1:0]        left_ff, left_in;        // window left edge
   logic [mwcs_pkg::TEXT_AW-1:0]      end_ff, end_in;          // newest text position
   logic [mwcs_pkg::PCNT_W-1:0]       needed_ff, needed_in;
   logic [mwcs_pkg::PCNT_W-1:0]       matched_ff, matched_in;
   logic [mwcs_pkg::TEXT_AW-1:0]      best_start_ff, best_start_in;
   logic [mwcs_pkg::LEN_W-1:0]        best_len_ff, best_len_in;
   logic                              found_ff, found_in;
   logic                              ovf_ff, ovf_in;
   logic [mwcs_pkg::SYM_W-1:0]        sym_ff, sym_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [mwcs_pkg::TEXT_AW-1:0]      rsp_start_ff, rsp_start_in;
   logic [mwcs_pkg::LEN_W-1:0]        rsp_len_ff, rsp_len_in;
   logic                              rsp_ovf_ff, rsp_ovf_in;

   // count tables
   mwcs_pkg::tbl_ctl_type             pat_ctl, win_ctl;
   logic [mwcs_pkg::PCNT_W-1:0]       pat_wr, pat_rd;
   logic [mwcs_pkg::WCNT_W-1:0]       win_wr, win_rd;
   logic [mwcs_pkg::SYM_W-1:0]        tbl_addr;
   logic [mwcs_pkg::WCNT_W-1:0]       pat_rd_ext;

   // text store
   logic [mwcs_pkg::SYM_W-1:0]        text_mem [mwcs_pkg::TEXT_DEPTH];
   logic                              text_we;
   logic [mwcs_pkg::SYM_W-1:0]        text_rd_ff;

   logic                              accept;
   logic [mwcs_pkg::LEN_W-1:0]        cur_len;
   logic [mwcs_pkg::POS_W-1:0]        left_next;

   assign accept     = req_ch.valid && req_ch.ready;
   assign pat_rd_ext = {{(mwcs_pkg::WCNT_W - mwcs_pkg::PCNT_W){1'b0}}, pat_rd};
   assign cur_len    = {1'b0, end_ff} - left_ff + 13'd1;
   assign left_next  = left_ff + 13'd1;

   mwcs_count_table #(.DATA_W(mwcs_pkg::PCNT_W)) u_pat_tbl (
      .clock   (clock),
      .reset   (reset),
      .ctl     (pat_ctl),
      .wr_data (pat_wr),
      .rd_data (pat_rd)
   );

   mwcs_count_table #(.DATA_W(mwcs_pkg::WCNT_W)) u_win_tbl (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .wr_data (win_wr),
      .rd_data (win_rd)
   );

   // text store: written at the tail, read at the left edge every cycle
   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[pos_ff[mwcs_pkg::TEXT_AW-1:0]] <= req_ch.symbol;
      end
      text_rd_ff <= text_mem[left_ff[mwcs_pkg::TEXT_AW-1:0]];
   end

   // table address follows the symbol being worked on
   always_comb begin
      unique case (state_ff)
         mwcs_pkg::ST_IDLE:                          tbl_addr = req_ch.symbol;
         mwcs_pkg::ST_LEFT_CHR, mwcs_pkg::ST_LEFT_CMP: tbl_addr = text_rd_ff;
         default:                                    tbl_addr = sym_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwcs_pkg::ST_IDLE;
         pos_ff       <= '0;
         left_ff      <= '0;
         end_ff       <= '0;
         needed_ff    <= '0;
         matched_ff   <= '0;
         best_start_ff <= '0;
         best_len_ff  <= '0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         end_ff       <= end_in;
         needed_ff    <= needed_in;
         matched_ff   <= matched_in;
         best_start_ff <= best_start_in;
         best_len_ff  <= best_len_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff       <= sym_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // sequencer: next state, datapath updates and table controls
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      end_in        = end_ff;
      needed_in     = needed_ff;
      matched_in    = matched_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      found_in      = found_ff;
      ovf_in        = ovf_ff;
      sym_in        = sym_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      pat_ctl       = '{clear: 1'b0, we: 1'b0, addr: tbl_addr};
      win_ctl       = '{clear: 1'b0, we: 1'b0, addr: tbl_addr};
      pat_wr        = pat_rd + 8'd1;
      win_wr        = win_rd + 13'd1;
      text_we       = 1'b0;
      req_ch.ready  = 1'b0;

      unique case (state_ff)
         mwcs_pkg::ST_IDLE: begin
            req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
            if (accept) begin
               sym_in   = req_ch.symbol;
               state_in = mwcs_pkg::ST_DONE;
               priority if (req_ch.opcode == mwcs_pkg::OP_CLEAR) begin
                  pat_ctl.clear = 1'b1;
                  win_ctl.clear = 1'b1;
                  pos_in        = '0;
                  left_in       = '0;
                  end_in        = '0;
                  needed_in     = '0;
                  matched_in    = '0;
                  best_start_in = '0;
                  best_len_in   = '0;
                  found_in      = 1'b0;
                  ovf_in        = 1'b0;
               end else if (req_ch.opcode == mwcs_pkg::OP_PATTERN) begin
                  // late pattern symbols are ignored without overflow
                  if (pos_ff == '0) begin
                     if (needed_ff >= mwcs_pkg::MAX_PATTERN) begin
                        ovf_in = 1'b1;
                     end else begin
                        state_in = mwcs_pkg::ST_PAT_UPD;
                     end
                  end
               end else if (req_ch.opcode == mwcs_pkg::OP_TEXT) begin
                  if (pos_ff >= 13'(mwcs_pkg::TEXT_DEPTH)) begin
                     ovf_in = 1'b1;
                  end else begin
                     text_we  = 1'b1;
                     end_in   = pos_ff[mwcs_pkg::TEXT_AW-1:0];
                     pos_in   = pos_ff + 13'd1;
                     state_in = mwcs_pkg::ST_TXT_UPD;
                  end
               end else begin
                  state_in = mwcs_pkg::ST_DONE;
               end
            end
         end

         mwcs_pkg::ST_PAT_UPD: begin
            pat_ctl.we = 1'b1;
            needed_in  = needed_ff + 8'd1;
            state_in   = mwcs_pkg::ST_DONE;
         end

         mwcs_pkg::ST_TXT_UPD: begin
            win_ctl.we = 1'b1;
            state_in   = mwcs_pkg::ST_DONE;
            if (pat_rd != '0) begin
               if (win_rd < pat_rd_ext) begin
                  matched_in = matched_ff + 8'd1;
               end
               // full cover: trim surplus from the left edge
               if (matched_in == needed_ff && left_ff <= {1'b0, end_ff}) begin
                  state_in = mwcs_pkg::ST_LEFT_CHR;
               end
            end
         end

         mwcs_pkg::ST_LEFT_RD: begin
            state_in = mwcs_pkg::ST_LEFT_CHR;
         end

         mwcs_pkg::ST_LEFT_CHR: begin
            state_in = mwcs_pkg::ST_LEFT_CMP;
         end

         mwcs_pkg::ST_LEFT_CMP: begin
            if (win_rd > pat_rd_ext) begin
               win_ctl.we = 1'b1;
               win_wr     = win_rd - 13'd1;
               left_in    = left_next;
               state_in   = (left_next <= {1'b0, end_ff}) ? mwcs_pkg::ST_LEFT_RD
                                                          : mwcs_pkg::ST_DONE;
            end else begin
               // ties keep the earlier window
               if (!found_ff || best_len_ff > cur_len) begin
                  best_len_in   = cur_len;
                  best_start_in = left_ff[mwcs_pkg::TEXT_AW-1:0];
                  found_in      = 1'b1;
               end
               state_in = mwcs_pkg::ST_DONE;
            end
         end

         mwcs_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_found_in = found_ff;
            rsp_start_in = found_ff ? best_start_ff : '0;
            rsp_len_in   = found_ff ? best_len_ff : '0;
            rsp_ovf_in   = ovf_ff;
            state_in     = mwcs_pkg::ST_IDLE;
         end

         default: begin
            state_in = mwcs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.window_start  = rsp_start_ff;
   assign rsp_ch.window_length = rsp_len_ff;
   assign rsp_ch.overflow      = rsp_ovf_ff;

endmodule

`default_nettype wire

/* tb/sv/minimum_window_cover_search_unit_tb.sv */
// ----------------------------------------------------------------------------
// minimum_window_cover_search_unit_tb: self-checking bench for the window search
// Streams clear, pattern and text transactions through the request channel,
// tracks the shortest covering window with a behavioral copy of the search,
// and compares every response field against it under varied back-pressure.
// ----------------------------------------------------------------------------
module minimum_window_cover_search_unit_tb;

   import mwcs_pkg::*;

   // opcode 3 is not decoded by the block; it only echoes the current result
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [SYM_W-1:0] CH_A = 7'd65;
   localparam logic [SYM_W-1:0] CH_B = 7'd66;
   localparam logic [SYM_W-1:0] CH_C = 7'd67;
   localparam logic [SYM_W-1:0] CH_LO = 7'd0;
   localparam logic [SYM_W-1:0] CH_HI = 7'd127;

   typedef struct packed {
      logic               found;
      logic [TEXT_AW-1:0] window_start;
      logic [LEN_W-1:0]   window_length;
      logic               overflow;
   } search_result_t;

   // one request transaction; given marks a row whose result is typed in
   typedef struct packed {
      logic [1:0]       opcode;
      logic [SYM_W-1:0] symbol;
      logic             given;
      search_result_t   result;
   } query_txn_t;

   localparam search_result_t NO_WINDOW = '0;
   localparam search_result_t AT_ZERO_LEN_ONE = '{1'b1, 12'd0, 13'd1, 1'b0};

   // Directed rows. Rows with given=1 carry a result that is obvious from the
   // stream so far (nothing found yet, or a one-symbol cover at position 0);
   // the rest are left to the window tracker below.
   localparam int DIRECTED_N = 21;
   localparam query_txn_t DIRECTED_ROWS [DIRECTED_N] = '{
      '{OP_UNUSED,  CH_LO, 1'b1, NO_WINDOW},       // straight out of reset
      '{OP_TEXT,    CH_HI, 1'b1, NO_WINDOW},       // empty pattern: never found
      '{OP_TEXT,    CH_LO, 1'b1, NO_WINDOW},
      '{OP_CLEAR,   CH_HI, 1'b1, NO_WINDOW},
      '{OP_PATTERN, CH_A,  1'b1, NO_WINDOW},       // pattern A B A
      '{OP_PATTERN, CH_B,  1'b1, NO_WINDOW},
      '{OP_PATTERN, CH_A,  1'b1, NO_WINDOW},
      '{OP_TEXT,    CH_A,  1'b1, NO_WINDOW},
      '{OP_TEXT,    CH_C,  1'b0, NO_WINDOW},
      '{OP_PATTERN, CH_C,  1'b0, NO_WINDOW},       // late pattern symbol, ignored
      '{OP_TEXT,    CH_B,  1'b0, NO_WINDOW},
      '{OP_TEXT,    CH_A,  1'b0, NO_WINDOW},       // first cover, length 4
      '{OP_TEXT,    CH_A,  1'b0, NO_WINDOW},       // left edge trims to length 3
      '{OP_TEXT,    CH_B,  1'b0, NO_WINDOW},       // trims again: length 3 at 3, earlier window kept
      '{OP_CLEAR,   CH_LO, 1'b1, NO_WINDOW},
      '{OP_PATTERN, CH_LO, 1'b0, NO_WINDOW},
      '{OP_TEXT,    CH_LO, 1'b1, AT_ZERO_LEN_ONE},
      '{OP_PATTERN, CH_HI, 1'b0, NO_WINDOW},       // late again
      '{OP_TEXT,    CH_HI, 1'b0, NO_WINDOW},
      '{OP_UNUSED,  CH_HI, 1'b0, NO_WINDOW},
      '{OP_CLEAR,   CH_LO, 1'b1, NO_WINDOW}
   };

   logic clock = 1'b0;
   logic reset;

   mwcs_req_if req_ch ();
   mwcs_rsp_if rsp_ch ();

   minimum_window_cover_search_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Window tracker: a behavioral copy of the search state
   // ---------------------------------------------------------------------------
   logic [PCNT_W-1:0]  pattern_tally [ALPHA_SIZE];
   logic [WCNT_W-1:0]  window_tally  [ALPHA_SIZE];
   logic [SYM_W-1:0]   text_mem      [TEXT_DEPTH];
   logic [POS_W-1:0]   text_len;
   logic [POS_W-1:0]   left_pos;
   logic [PCNT_W-1:0]  needed_cnt;
   logic [PCNT_W-1:0]  matched_cnt;
   logic [TEXT_AW-1:0] best_start;
   logic [LEN_W-1:0]   best_len;
   logic               best_found;
   logic               overflow_seen;

   function automatic void clear_tracker();
      for (int i = 0; i < ALPHA_SIZE; i++) begin
         pattern_tally[i] = '0;
         window_tally[i]  = '0;
      end
      text_len      = '0;
      left_pos      = '0;
      needed_cnt    = '0;
      matched_cnt   = '0;
      best_start    = '0;
      best_len      = '0;
      best_found    = 1'b0;
      overflow_seen = 1'b0;
   endfunction

   // Applies one accepted transaction and returns the response it must cause.
   function automatic search_result_t predict_search(logic [1:0] op, logic [SYM_W-1:0] sym);
      search_result_t   r;
      logic [POS_W-1:0] tail;
      logic [POS_W-1:0] span;
      logic [SYM_W-1:0] c;
      logic             settled;
      case (op)
         OP_CLEAR: begin
            clear_tracker();
         end
         OP_PATTERN: begin
            // pattern symbols only count before the first text symbol
            if (text_len == 0) begin
               if (needed_cnt == MAX_PATTERN) begin
                  overflow_seen = 1'b1;
               end else begin
                  pattern_tally[sym]++;
                  needed_cnt++;
               end
            end
         end
         OP_TEXT: begin
            if (text_len == TEXT_DEPTH) begin
               overflow_seen = 1'b1;
            end else begin
               tail = text_len;
               text_mem[tail[TEXT_AW-1:0]] = sym;
               text_len++;
               if (pattern_tally[sym] == 0) begin
                  window_tally[sym]++;
               end else begin
                  if (window_tally[sym] < pattern_tally[sym])
                     matched_cnt++;
                  window_tally[sym]++;
                  if (needed_cnt != 0 && matched_cnt == needed_cnt) begin
                     // drop surplus symbols off the left, then score the window
                     settled = 1'b0;
                     while (!settled && left_pos <= tail) begin
                        c = text_mem[left_pos[TEXT_AW-1:0]];
                        if (window_tally[c] > pattern_tally[c]) begin
                           window_tally[c]--;
                           left_pos++;
                        end else begin
                           span = tail - left_pos + 1'b1;
                           if (!best_found || best_len > span) begin
                              best_len   = span;
                              best_start = left_pos[TEXT_AW-1:0];
                              best_found = 1'b1;
                           end
                           settled = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      r.found         = best_found;
      r.window_start  = best_found ? best_start : '0;
      r.window_length = best_found ? best_len : '0;
      r.overflow      = overflow_seen;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus queue and request driver
   // ---------------------------------------------------------------------------
   query_txn_t     pending_txns [$];
   search_result_t expected_results [$];
   query_txn_t     cur_txn;
   search_result_t tracked;
   int             send_idle_pct;
   int             stall_pct;
   int             mismatch_count;

   function automatic void queue_txn(logic [1:0] op, logic [SYM_W-1:0] sym);
      query_txn_t t;
      t.opcode = op;
      t.symbol = sym;
      t.given  = 1'b0;
      t.result = NO_WINDOW;
      pending_txns.push_back(t);
   endfunction

   function automatic logic [SYM_W-1:0] symbol_other_than(logic [SYM_W-1:0] a,
                                                        logic [SYM_W-1:0] b);
      logic [SYM_W-1:0] s;
      do
         s = SYM_W'($urandom_range(127));
      while (s == a || s == b);
      return s;
   endfunction

   // Slot is free when nothing is offered or the offer is taken this edge.
   // Each accepted transaction is run through the tracker; rows with a typed
   // result are checked against that instead.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            tracked = predict_search(cur_txn.opcode, cur_txn.symbol);
            expected_results.push_back(cur_txn.given ? cur_txn.result : tracked);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_txn = pending_txns.pop_front();
               req_ch.valid  <= 1'b1;
               req_ch.opcode <= cur_txn.opcode;
               req_ch.symbol <= cur_txn.symbol;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response checker with random stalls
   // ---------------------------------------------------------------------------
   search_result_t want;
   search_result_t got;

   task automatic compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.found         = rsp_ch.found;
            got.window_start  = rsp_ch.window_start;
            got.window_length = rsp_ch.window_length;
            got.overflow      = rsp_ch.overflow;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
               mismatch_count++;
            end else if ($isunknown(got)) begin
               want = expected_results.pop_front();
               $display("%0t: unknown bits, expected %h, actual %h", $time, want, got);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("found", want.found, got.found);
               compare_field("window_start", want.window_start, got.window_start);
               compare_field("window_length", want.window_length, got.window_length);
               compare_field("overflow", want.overflow, got.overflow);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------------

   // One query with random content over a small alphabet, so covers are
   // common. A few queries skip the clear and carry on from the last one;
   // some text positions are replaced by late pattern symbols or opcode 3.
   task automatic add_random_query(output int pushed);
      logic [SYM_W-1:0] alpha [8];
      int               n_alpha;
      int               n_pat;
      int               n_txt;
      int               roll;
      pushed  = 0;
      n_alpha = $urandom_range(8, 2);
      for (int i = 0; i < n_alpha; i++)
         alpha[i] = SYM_W'($urandom_range(127));
      if ($urandom_range(99) < 90) begin
         queue_txn(OP_CLEAR, SYM_W'($urandom_range(127)));
         pushed++;
      end
      roll  = $urandom_range(99);
      n_pat = (roll < 5) ? 0 : (roll < 75) ? $urandom_range(4, 1) : $urandom_range(12, 5);
      for (int i = 0; i < n_pat; i++) begin
         queue_txn(OP_PATTERN, alpha[$urandom_range(n_alpha - 1)]);
         pushed++;
      end
      n_txt = $urandom_range(48, 4);
      for (int i = 0; i < n_txt; i++) begin
         roll = $urandom_range(99);
         if (roll < 3)
            queue_txn(OP_UNUSED, SYM_W'($urandom_range(127)));
         else if (roll < 6)
            queue_txn(OP_PATTERN, alpha[$urandom_range(n_alpha - 1)]);
         else if (roll < 88)
            queue_txn(OP_TEXT, alpha[$urandom_range(n_alpha - 1)]);
         else
            queue_txn(OP_TEXT, SYM_W'($urandom_range(127)));
         pushed++;
      end
   endtask

   task automatic add_random_phase(int target);
      int total;
      int n;
      total = 0;
      while (total < target) begin
         add_random_query(n);
         total += n;
      end
   endtask

   // Capacity queries: a full pattern over two symbols with one symbol past
   // the limit, then a long window whose two pattern symbols sit at both
   // ends, after which the left edge sweeps across the whole span.
   task automatic add_capacity_queries();
      logic [SYM_W-1:0] a;
      logic [SYM_W-1:0] b;
      a = SYM_W'($urandom_range(127));
      b = symbol_other_than(a, a);
      queue_txn(OP_CLEAR, CH_LO);
      for (int i = 0; i < 256; i++)
         queue_txn(OP_PATTERN, $urandom_range(1) ? a : b);   // last one is dropped
      for (int i = 0; i < 40; i++)
         queue_txn(OP_TEXT, $urandom_range(1) ? a : b);
      queue_txn(OP_PATTERN, a);

      queue_txn(OP_CLEAR, CH_HI);
      queue_txn(OP_PATTERN, a);
      queue_txn(OP_PATTERN, b);
      queue_txn(OP_TEXT, a);
      for (int i = 0; i < 200; i++)
         queue_txn(OP_TEXT, symbol_other_than(a, b));
      queue_txn(OP_TEXT, b);                                 // length 202 window
      queue_txn(OP_TEXT, a);                                 // long left edge trim
      queue_txn(OP_UNUSED, CH_LO);
   endtask

   // Holds the phase sequence back until every queued transaction has been answered.
   // Sampled on the falling edge so all edge updates have settled.
   task automatic wait_for_quiet();
      while (pending_txns.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.opcode  = OP_CLEAR;
      req_ch.symbol  = '0;
      rsp_ch.ready   = 1'b0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      mismatch_count = 0;
      clear_tracker();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no idling: directed rows, capacity queries, then random queries
      @(negedge clock);
      for (int i = 0; i < DIRECTED_N; i++)
         pending_txns.push_back(DIRECTED_ROWS[i]);
      add_capacity_queries();
      add_random_phase(220);
      wait_for_quiet();

      // sender mostly idle
      send_idle_pct = 77;
      stall_pct     = 0;
      add_random_phase(220);
      wait_for_quiet();

      // receiver mostly stalled
      send_idle_pct = 0;
      stall_pct     = 77;
      add_random_phase(220);
      wait_for_quiet();

      // both sides idle now and then
      send_idle_pct = 17;
      stall_pct     = 17;
      add_random_phase(220);
      wait_for_quiet();

      // any stray response would land in this window
      repeat (32) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* minimum_window_cover_search_unit.f */
sv/mwcs_pkg.sv
sv/mwcs_if.sv
sv/mwcs_count_table.sv
sv/minimum_window_cover_search_unit.sv
tb/sv/minimum_window_cover_search_unit_tb.sv
